/* src/mmt_pkg.sv */
// Shared constants, types and codes for the matrix multiply with transpose block.
`timescale 1ns / 1ps

package mmt_pkg;

  // Sizing
  localparam int MAX_DIM     = 64;
  localparam int DATA_WIDTH  = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int DIM_W  = 7;
  localparam int SIZE_W = 2 * DIM_W;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 16;
  localparam int POS_W  = 6;
  localparam int RES_W  = 38;
  localparam int STAT_W = 2;

  // Register port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int RSEL_W  = PADDR_W - 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CALC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DIM   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Register map, word index
  localparam logic [RSEL_W-1:0] REG_ROWS_A  = 3'd0;
  localparam logic [RSEL_W-1:0] REG_COLS_A  = 3'd1;
  localparam logic [RSEL_W-1:0] REG_ROWS_B  = 3'd2;
  localparam logic [RSEL_W-1:0] REG_COLS_B  = 3'd3;
  localparam logic [RSEL_W-1:0] REG_TRANS_A = 3'd4;
  localparam logic [RSEL_W-1:0] REG_TRANS_B = 3'd5;

  typedef logic [DIM_W-1:0]               dim_t;
  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic signed [DATA_WIDTH-1:0]   data_t;
  typedef logic signed [2*DATA_WIDTH-1:0] prod_t;
  typedef logic signed [RES_W-1:0]        res_t;

  // Effective configuration seen by the datapath
  typedef struct packed {
    dim_t rows_a;
    dim_t cols_a;
    dim_t rows_b;
    dim_t cols_b;
    logic trans_a;
    logic trans_b;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic setup;
    logic step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run;
    logic last;
    logic pipe_busy;
  } sts_t;

endpackage

/* src/mmt_if.sv */
// Item and result channel interfaces for the matrix multiply block.
`timescale 1ns / 1ps

interface mmt_in_if;
  logic                              valid;
  logic                              ready;
  logic [mmt_pkg::MODE_W-1:0]        mode;
  logic [mmt_pkg::IDX_W-1:0]         index;
  logic signed [mmt_pkg::VAL_W-1:0]  value;
  logic [mmt_pkg::POS_W-1:0]         out_row;
  logic [mmt_pkg::POS_W-1:0]         out_col;

  modport source (output valid, mode, index, value, out_row, out_col, input ready);
  modport sink   (input valid, mode, index, value, out_row, out_col, output ready);
endinterface

interface mmt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mmt_pkg::RES_W-1:0]  result;
  logic [mmt_pkg::STAT_W-1:0]        status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

/* src/mmt_cfg.sv */
// Register file on the APB-style port, with dimension saturation.
`timescale 1ns / 1ps

module mmt_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mmt_pkg::PADDR_W-1:0]  paddr,
  input  logic [mmt_pkg::PDATA_W-1:0]  pwdata,
  output logic [mmt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output mmt_pkg::cfg_t                cfg
);

  mmt_pkg::dim_t rows_a_r, rows_a_nxt;
  mmt_pkg::dim_t cols_a_r, cols_a_nxt;
  mmt_pkg::dim_t rows_b_r, rows_b_nxt;
  mmt_pkg::dim_t cols_b_r, cols_b_nxt;
  logic          trans_a_r, trans_a_nxt;
  logic          trans_b_r, trans_b_nxt;

  logic                        wr_en;
  logic [mmt_pkg::RSEL_W-1:0]  sel;

  // Clamp a dimension to MAX_DIM, the largest the stores hold
  function automatic mmt_pkg::dim_t sat_dim(input mmt_pkg::dim_t d);
    if (int'(d) > mmt_pkg::MAX_DIM) begin
      return mmt_pkg::DIM_W'(mmt_pkg::MAX_DIM);
    end
    return d;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = paddr[mmt_pkg::PADDR_W-1:2];

  // Write decode
  always_comb begin
    rows_a_nxt  = rows_a_r;
    cols_a_nxt  = cols_a_r;
    rows_b_nxt  = rows_b_r;
    cols_b_nxt  = cols_b_r;
    trans_a_nxt = trans_a_r;
    trans_b_nxt = trans_b_r;
    if (wr_en) begin
      case (sel)
        mmt_pkg::REG_ROWS_A:  rows_a_nxt  = pwdata[mmt_pkg::DIM_W-1:0];
        mmt_pkg::REG_COLS_A:  cols_a_nxt  = pwdata[mmt_pkg::DIM_W-1:0];
        mmt_pkg::REG_ROWS_B:  rows_b_nxt  = pwdata[mmt_pkg::DIM_W-1:0];
        mmt_pkg::REG_COLS_B:  cols_b_nxt  = pwdata[mmt_pkg::DIM_W-1:0];
        mmt_pkg::REG_TRANS_A: trans_a_nxt = pwdata[0];
        mmt_pkg::REG_TRANS_B: trans_b_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r  <= mmt_pkg::dim_t'(1);
      cols_a_r  <= mmt_pkg::dim_t'(1);
      rows_b_r  <= mmt_pkg::dim_t'(1);
      cols_b_r  <= mmt_pkg::dim_t'(1);
      trans_a_r <= 1'b0;
      trans_b_r <= 1'b0;
    end else begin
      rows_a_r  <= rows_a_nxt;
      cols_a_r  <= cols_a_nxt;
      rows_b_r  <= rows_b_nxt;
      cols_b_r  <= cols_b_nxt;
      trans_a_r <= trans_a_nxt;
      trans_b_r <= trans_b_nxt;
    end
  end

  // Read back the raw register values
  always_comb begin
    case (sel)
      mmt_pkg::REG_ROWS_A:  prdata = mmt_pkg::PDATA_W'(rows_a_r);
      mmt_pkg::REG_COLS_A:  prdata = mmt_pkg::PDATA_W'(cols_a_r);
      mmt_pkg::REG_ROWS_B:  prdata = mmt_pkg::PDATA_W'(rows_b_r);
      mmt_pkg::REG_COLS_B:  prdata = mmt_pkg::PDATA_W'(cols_b_r);
      mmt_pkg::REG_TRANS_A: prdata = mmt_pkg::PDATA_W'(trans_a_r);
      mmt_pkg::REG_TRANS_B: prdata = mmt_pkg::PDATA_W'(trans_b_r);
      default:              prdata = '0;
    endcase
  end

  // Effective sizes
  assign cfg.rows_a  = sat_dim(rows_a_r);
  assign cfg.cols_a  = sat_dim(cols_a_r);
  assign cfg.rows_b  = sat_dim(rows_b_r);
  assign cfg.cols_b  = sat_dim(cols_b_r);
  assign cfg.trans_a = trans_a_r;
  assign cfg.trans_b = trans_b_r;

endmodule

/* src/mmt_dp.sv */
// Datapath: item register, element stores, address walkers, multiply-accumulate, result register.
`timescale 1ns / 1ps

module mmt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mmt_pkg::cfg_t                    cfg,
  input  mmt_pkg::cmd_t                    cmd,
  output mmt_pkg::sts_t                    sts,
  input  logic [mmt_pkg::MODE_W-1:0]       in_mode,
  input  logic [mmt_pkg::IDX_W-1:0]        in_index,
  input  logic signed [mmt_pkg::VAL_W-1:0] in_value,
  input  logic [mmt_pkg::POS_W-1:0]        in_out_row,
  input  logic [mmt_pkg::POS_W-1:0]        in_out_col,
  output logic signed [mmt_pkg::RES_W-1:0] out_result,
  output logic [mmt_pkg::STAT_W-1:0]       out_status
);

  // Latched item
  logic [mmt_pkg::MODE_W-1:0]       mode_r;
  logic [mmt_pkg::IDX_W-1:0]        idx_r;
  logic signed [mmt_pkg::VAL_W-1:0] val_r;
  logic [mmt_pkg::POS_W-1:0]        row_r;
  logic [mmt_pkg::POS_W-1:0]        col_r;

  // Element stores
  mmt_pkg::data_t a_mem [mmt_pkg::STORE_DEPTH];
  mmt_pkg::data_t b_mem [mmt_pkg::STORE_DEPTH];

  // Walk state
  mmt_pkg::addr_t a_addr_r, b_addr_r, a_inc_r, b_inc_r;
  mmt_pkg::dim_t  k_len_r, k_cnt_r;
  mmt_pkg::data_t a_rd_r, b_rd_r;
  mmt_pkg::prod_t prod_r;
  mmt_pkg::res_t  acc_r;
  logic           rd_v_r, prod_v_r;
  logic [mmt_pkg::STAT_W-1:0] stat_r;
  mmt_pkg::res_t  res_out_r;
  logic [mmt_pkg::STAT_W-1:0] stat_out_r;

  // Setup decode
  mmt_pkg::dim_t              m_len, n_len, k_len, k_chk;
  logic [mmt_pkg::SIZE_W-1:0] size_a, size_b, size_sel;
  logic                       idx_bad;
  logic [mmt_pkg::STAT_W-1:0] stat_c;
  logic                       run_c, wr_a, wr_b;
  mmt_pkg::addr_t             a_start, b_start, a_inc, b_inc, wr_addr;
  mmt_pkg::data_t             wr_data;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      idx_r  <= in_index;
      val_r  <= in_value;
      row_r  <= in_out_row;
      col_r  <= in_out_col;
    end
  end

  // Shapes of op(A) and op(B)
  assign m_len = cfg.trans_a ? cfg.cols_a : cfg.rows_a;
  assign k_len = cfg.trans_a ? cfg.rows_a : cfg.cols_a;
  assign k_chk = cfg.trans_b ? cfg.cols_b : cfg.rows_b;
  assign n_len = cfg.trans_b ? cfg.rows_b : cfg.cols_b;

  // Load range check
  assign size_a   = mmt_pkg::SIZE_W'(cfg.rows_a) * mmt_pkg::SIZE_W'(cfg.cols_a);
  assign size_b   = mmt_pkg::SIZE_W'(cfg.rows_b) * mmt_pkg::SIZE_W'(cfg.cols_b);
  assign size_sel = (mode_r == mmt_pkg::MODE_LD_A) ? size_a : size_b;
  assign idx_bad  = (mmt_pkg::SIZE_W'(idx_r) >= size_sel) ||
                    (32'(idx_r) >= 32'(mmt_pkg::STORE_DEPTH));
  assign wr_addr  = mmt_pkg::ADDR_W'(idx_r);
  assign wr_data  = mmt_pkg::data_t'(val_r);

  // Item classification
  always_comb begin
    stat_c = mmt_pkg::STAT_OK;
    run_c  = 1'b0;
    wr_a   = 1'b0;
    wr_b   = 1'b0;
    case (mode_r)
      mmt_pkg::MODE_LD_A: begin
        if (idx_bad) stat_c = mmt_pkg::STAT_RANGE;
        else         wr_a   = 1'b1;
      end
      mmt_pkg::MODE_LD_B: begin
        if (idx_bad) stat_c = mmt_pkg::STAT_RANGE;
        else         wr_b   = 1'b1;
      end
      mmt_pkg::MODE_CALC: begin
        if (k_len != k_chk) begin
          stat_c = mmt_pkg::STAT_DIM;
        end else if ((mmt_pkg::DIM_W'(row_r) >= m_len) ||
                     (mmt_pkg::DIM_W'(col_r) >= n_len)) begin
          stat_c = mmt_pkg::STAT_RANGE;
        end else begin
          run_c = (k_len != '0);
        end
      end
      default: stat_c = mmt_pkg::STAT_RANGE;
    endcase
  end

  // Start address and stride of each walk
  assign a_start = cfg.trans_a ? mmt_pkg::ADDR_W'(row_r)
                 : mmt_pkg::ADDR_W'(mmt_pkg::SIZE_W'(row_r) * mmt_pkg::SIZE_W'(cfg.cols_a));
  assign a_inc   = cfg.trans_a ? mmt_pkg::ADDR_W'(cfg.cols_a) : mmt_pkg::addr_t'(1);
  assign b_start = cfg.trans_b
                 ? mmt_pkg::ADDR_W'(mmt_pkg::SIZE_W'(col_r) * mmt_pkg::SIZE_W'(cfg.cols_b))
                 : mmt_pkg::ADDR_W'(col_r);
  assign b_inc   = cfg.trans_b ? mmt_pkg::addr_t'(1) : mmt_pkg::ADDR_W'(cfg.cols_b);

  // Store A: load write port, walk read port
  always_ff @(posedge clk) begin
    if (cmd.setup && wr_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      a_rd_r <= a_mem[a_addr_r];
    end
  end

  // Store B
  always_ff @(posedge clk) begin
    if (cmd.setup && wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      b_rd_r <= b_mem[b_addr_r];
    end
  end

  // Address walkers and inner counter
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      a_addr_r <= a_start;
      b_addr_r <= b_start;
      a_inc_r  <= a_inc;
      b_inc_r  <= b_inc;
      k_len_r  <= k_len;
      k_cnt_r  <= '0;
      stat_r   <= stat_c;
    end else if (cmd.step) begin
      a_addr_r <= a_addr_r + a_inc_r;
      b_addr_r <= b_addr_r + b_inc_r;
      k_cnt_r  <= k_cnt_r + mmt_pkg::dim_t'(1);
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.step;
      prod_v_r <= rd_v_r;
    end
  end

  // Multiply then accumulate, wrapping at the result width
  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (cmd.setup) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + mmt_pkg::res_t'(prod_r);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_out_r  <= acc_r;
      stat_out_r <= stat_r;
    end
  end

  assign out_result    = res_out_r;
  assign out_status    = stat_out_r;
  assign sts.run       = run_c;
  assign sts.last      = (k_cnt_r + mmt_pkg::dim_t'(1)) == k_len_r;
  assign sts.pipe_busy = rd_v_r | prod_v_r;

endmodule

/* src/mmt_ctrl.sv */
// Controller: item sequencing state machine and result valid.
`timescale 1ns / 1ps

module mmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mmt_pkg::cmd_t cmd,
  input  mmt_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.run ? ST_RUN : ST_DONE;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid: refilled in the same cycle it is taken
  always_comb begin
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !sts.pipe_busy)
    else $error("result taken before the accumulate pipeline drained");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.pipe_busy)
    else $error("pipeline active while waiting for an item");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result valid raised outside the completion state");
`endif

endmodule

/* src/matrix_multiply_transpose.sv */
// Top level of the matrix multiply with transpose flags.
`timescale 1ns / 1ps

// Usage:
//  in_ch carries items: mode 0/1 loads one Q8.8 element of A/B at a row-major
//  index, mode 2 asks for one output element (out_row, out_col) of
//  op(A) * op(B). Every item gives exactly one transfer on out_ch: the Q22.16
//  dot product (zero for loads and errors) and a status code.
//  The cfg_ APB-style port sets the four dimensions and the two transpose
//  flags; write it only while no item is in flight.
//  One item is handled at a time. A load, an error or a K = 0 compute goes
//  from setup straight to completion; any other compute walks the K inner
//  elements one per cycle with the single multiply-accumulate behind the
//  registered store reads and lets that pipeline drain before completing.
//  The result sits in an output register, so the next item is taken while
//  a finished result still waits; if out_ch stalls, a second result waits
//  inside until the register frees.
//  Reset (rst_n, synchronous) restores the register defaults and empties the
//  control path at once; the element stores are not cleared, so elements must
//  be loaded before they are used.

module matrix_multiply_transpose (
  input  logic                        clk,
  input  logic                        rst_n,
  mmt_in_if.sink                      in_ch,
  mmt_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mmt_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [mmt_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [mmt_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  mmt_pkg::cfg_t cfg;
  mmt_pkg::cmd_t cmd;
  mmt_pkg::sts_t sts;

  // Configuration registers
  mmt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Sequencing
  mmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Stores and arithmetic
  mmt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_ch.mode),
    .in_index   (in_ch.index),
    .in_value   (in_ch.value),
    .in_out_row (in_ch.out_row),
    .in_out_col (in_ch.out_col),
    .out_result (out_ch.result),
    .out_status (out_ch.status)
  );

endmodule
